// ===== design/assert_macros.svh =====
// Assertion helpers used by the list sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition on every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// Check a consequence in the same cycle as its cause
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ilist_pkg.sv =====
`timescale 1ns / 1ps

package ilist_pkg;

  // Built storage
  localparam int DEPTH      = 64;
  localparam int WORD_WIDTH = 32;

  // Transaction field widths
  localparam int ACTION_W = 3;
  localparam int INDEX_W  = 7;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 7;
  localparam int CAP_W    = 7;

  localparam int CAP_RESET = 64;

  // Derived widths
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  typedef enum logic [ACTION_W-1:0] {
    ACT_READ   = 3'd0,
    ACT_APPEND = 3'd1,
    ACT_INSERT = 3'd2,
    ACT_DELETE = 3'd3,
    ACT_EDIT   = 3'd4,
    ACT_CLEAR  = 3'd5
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 2'd0,
    STS_BAD_INDEX = 2'd1,
    STS_FULL      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ_WAIT,
    S_SHIFT,
    S_FINISH,
    S_DONE
  } state_t;

  // Memory port commands from the sequencer
  typedef struct packed {
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [WORD_WIDTH-1:0] wdata;
    logic                  re;
    logic [ADDR_W-1:0]     raddr;
  } ram_cmd_t;

  // Status from the top level to the sequencer
  typedef struct packed {
    logic             out_free;
    logic [CAP_W-1:0] cap;
  } ctl_stat_t;

  // Finished result handed to the output register
  typedef struct packed {
    logic                load;
    logic [VALUE_W-1:0]  read_value;
    status_t             status;
    logic [FILL_W-1:0]   fill_count;
    logic                is_empty;
    logic                is_full;
  } result_t;

  // Sign-extend (or trim) a stored word to the read port width
  function automatic logic [VALUE_W-1:0] sext_word(input logic [WORD_WIDTH-1:0] w);
    logic signed [WORD_WIDTH-1:0] s;
    s = w;
    return VALUE_W'(s);
  endfunction

endpackage

// ===== design/ilist_ifs.sv =====
`timescale 1ns / 1ps

// Request channel: one list action per transaction
interface ilist_req_if;
  import ilist_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic [INDEX_W-1:0]         index;
  logic signed [VALUE_W-1:0]  value;

  modport source(output valid, action, index, value, input ready);
  modport sink(input valid, action, index, value, output ready);
endinterface

// Response channel: one result per request
interface ilist_rsp_if;
  import ilist_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  read_value;
  logic [STATUS_W-1:0]        status;
  logic [FILL_W-1:0]          fill_count;
  logic                       is_empty;
  logic                       is_full;

  modport source(output valid, read_value, status, fill_count, is_empty, is_full,
                 input ready);
  modport sink(input valid, read_value, status, fill_count, is_empty, is_full,
               output ready);
endinterface

// ===== design/indexed_list_insert_delete.sv =====
`timescale 1ns / 1ps

// Ordered list of signed words with read, append, insert, delete, edit and
// clear. Requests arrive on req and each produces exactly one result on rsp;
// both channels use a valid/ready handshake. cfg_we/cfg_wdata set the
// capacity in use (reset 64, clamped to the built depth); write it only
// while the block is idle.
// Append, edit, clear, failed actions and the end-of-list insert or delete
// pass from decode straight to done; a read adds a wait state for the
// registered memory read; an insert or delete in the middle of the list
// first moves the affected entries through the single memory, one entry
// per cycle, then finishes. One request is worked on at a time; req.ready
// is high only while the sequencer is idle.
// A result waits in the output register while rsp.ready is low; the next
// request is still accepted and processed, and only its own result waits
// until the register empties.
// Reset empties the list and restores the capacity; the memory itself is
// not cleared, as only positions below the count are ever read.
module indexed_list_insert_delete (
  input  logic                         clk,
  input  logic                         rst,
  ilist_req_if.sink                    req,
  ilist_rsp_if.source                  rsp,
  input  logic                         cfg_we,
  input  logic [ilist_pkg::CAP_W-1:0]  cfg_wdata
);
  import ilist_pkg::*;

  logic [CAP_W-1:0]      cap;
  ctl_stat_t             ctl;
  ram_cmd_t              ram;
  result_t               res;
  logic [WORD_WIDTH-1:0] rdata;

  logic                  out_valid;
  logic [VALUE_W-1:0]    out_rd;
  status_t               out_st;
  logic [FILL_W-1:0]     out_fill;
  logic                  out_empty;
  logic                  out_full;

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_W'(CAP_RESET);
    end else if (cfg_we) begin
      cap <= cfg_wdata;
    end
  end

  assign ctl.out_free = !out_valid || rsp.ready;
  assign ctl.cap      = cap;

  ilist_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram.we),
    .waddr (ram.waddr),
    .wdata (ram.wdata),
    .re    (ram.re),
    .raddr (ram.raddr),
    .rdata (rdata)
  );

  ilist_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .ctl   (ctl),
    .rdata (rdata),
    .ram   (ram),
    .res   (res)
  );

  // Output register: hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      out_rd    <= res.read_value;
      out_st    <= res.status;
      out_fill  <= res.fill_count;
      out_empty <= res.is_empty;
      out_full  <= res.is_full;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.read_value = out_rd;
  assign rsp.status     = out_st;
  assign rsp.fill_count = out_fill;
  assign rsp.is_empty   = out_empty;
  assign rsp.is_full    = out_full;

endmodule

// ===== design/ilist_ram.sv =====
`timescale 1ns / 1ps

module ilist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/ilist_seq.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ilist_seq (
  input  logic                        clk,
  input  logic                        rst,
  ilist_req_if.sink                   req,
  input  ilist_pkg::ctl_stat_t        ctl,
  input  logic [ilist_pkg::WORD_WIDTH-1:0] rdata,
  output ilist_pkg::ram_cmd_t         ram,
  output ilist_pkg::result_t          res
);
  import ilist_pkg::*;

  state_t                state, state_next;
  action_t               act, act_next;
  logic [INDEX_W-1:0]    idx, idx_next;
  logic [WORD_WIDTH-1:0] val, val_next;
  logic [CNT_W-1:0]      count, count_next;
  logic [ADDR_W-1:0]     rptr, rptr_next;
  logic [ADDR_W-1:0]     wptr, wptr_next;
  logic                  more, more_next;
  logic                  pend, pend_next;
  logic [VALUE_W-1:0]    res_rd, res_rd_next;
  status_t               res_st, res_st_next;

  logic [CMP_W-1:0]      idx_c, cnt_c, cap_w, cap_c;
  logic [ADDR_W-1:0]     idx_a, cnt_a;
  logic                  full, up, last_rd;

  // Compare index, count and capacity at a common width
  assign idx_c = CMP_W'(idx);
  assign cnt_c = CMP_W'(count);
  assign cap_w = CMP_W'(ctl.cap);
  assign cap_c = (cap_w < CMP_W'(DEPTH)) ? cap_w : CMP_W'(DEPTH);
  assign full  = (cnt_c >= cap_c);
  assign idx_a = ADDR_W'(idx);
  assign cnt_a = ADDR_W'(count);
  assign up    = (act == ACT_INSERT);
  assign last_rd = up ? (rptr == idx_a)
                      : ((CMP_W'(rptr) + CMP_W'(1)) == cnt_c);

  assign req.ready = (state == S_IDLE);

  // Present the finished result
  assign res.load       = (state == S_DONE) && ctl.out_free;
  assign res.read_value = res_rd;
  assign res.status     = res_st;
  assign res.fill_count = FILL_W'(count);
  assign res.is_empty   = (count == '0);
  assign res.is_full    = full;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      more  <= 1'b0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      more  <= more_next;
      pend  <= pend_next;
    end
  end

  // Transaction and pointer registers
  always_ff @(posedge clk) begin
    act    <= act_next;
    idx    <= idx_next;
    val    <= val_next;
    rptr   <= rptr_next;
    wptr   <= wptr_next;
    res_rd <= res_rd_next;
    res_st <= res_st_next;
  end

  // Sequencer: decode, shift one entry per cycle, finish
  always_comb begin
    state_next  = state;
    act_next    = act;
    idx_next    = idx;
    val_next    = val;
    count_next  = count;
    rptr_next   = rptr;
    wptr_next   = wptr;
    more_next   = more;
    pend_next   = pend;
    res_rd_next = res_rd;
    res_st_next = res_st;
    ram         = '0;

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          act_next   = action_t'(req.action);
          idx_next   = req.index;
          val_next   = WORD_WIDTH'(req.value);
          state_next = S_DECODE;
        end
      end

      S_DECODE: begin
        res_rd_next = '0;
        res_st_next = STS_OK;
        state_next  = S_DONE;
        unique case (act)
          ACT_READ: begin
            if (idx_c < cnt_c) begin
              ram.re     = 1'b1;
              ram.raddr  = idx_a;
              state_next = S_READ_WAIT;
            end else begin
              res_rd_next = '1;
              res_st_next = STS_BAD_INDEX;
            end
          end
          ACT_APPEND: begin
            if (full) begin
              res_st_next = STS_FULL;
            end else begin
              ram.we     = 1'b1;
              ram.waddr  = cnt_a;
              ram.wdata  = val;
              count_next = count + CNT_W'(1);
            end
          end
          ACT_INSERT: begin
            if (idx_c > cnt_c) begin
              res_st_next = STS_BAD_INDEX;
            end else if (full) begin
              res_st_next = STS_FULL;
            end else if (idx_c == cnt_c) begin
              ram.we     = 1'b1;
              ram.waddr  = idx_a;
              ram.wdata  = val;
              count_next = count + CNT_W'(1);
            end else begin
              rptr_next  = ADDR_W'(count - CNT_W'(1));
              more_next  = 1'b1;
              pend_next  = 1'b0;
              state_next = S_SHIFT;
            end
          end
          ACT_DELETE: begin
            if (idx_c >= cnt_c) begin
              res_st_next = STS_BAD_INDEX;
            end else if ((idx_c + CMP_W'(1)) == cnt_c) begin
              count_next = count - CNT_W'(1);
            end else begin
              rptr_next  = idx_a + ADDR_W'(1);
              more_next  = 1'b1;
              pend_next  = 1'b0;
              state_next = S_SHIFT;
            end
          end
          ACT_EDIT: begin
            if (idx_c >= cnt_c) begin
              res_st_next = STS_BAD_INDEX;
            end else begin
              ram.we    = 1'b1;
              ram.waddr = idx_a;
              ram.wdata = val;
            end
          end
          ACT_CLEAR: begin
            count_next = '0;
          end
          default: begin
          end
        endcase
      end

      S_READ_WAIT: begin
        res_rd_next = sext_word(rdata);
        state_next  = S_DONE;
      end

      S_SHIFT: begin
        // Issue the next read while the previous word is written back
        if (more) begin
          ram.re    = 1'b1;
          ram.raddr = rptr;
          pend_next = 1'b1;
          wptr_next = up ? rptr + ADDR_W'(1) : rptr - ADDR_W'(1);
          if (last_rd) begin
            more_next = 1'b0;
          end else begin
            rptr_next = up ? rptr - ADDR_W'(1) : rptr + ADDR_W'(1);
          end
        end else begin
          pend_next = 1'b0;
        end
        if (pend) begin
          ram.we    = 1'b1;
          ram.waddr = wptr;
          ram.wdata = rdata;
        end
        if (!more && pend) begin
          state_next = S_FINISH;
        end
      end

      S_FINISH: begin
        // Drop the new word into the gap, or close the list up
        if (up) begin
          ram.we     = 1'b1;
          ram.waddr  = idx_a;
          ram.wdata  = val;
          count_next = count + CNT_W'(1);
        end else begin
          count_next = count - CNT_W'(1);
        end
        state_next = S_DONE;
      end

      S_DONE: begin
        if (ctl.out_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `ASSERT_ALWAYS(a_count_max, clk, rst, count <= CNT_W'(DEPTH), "entry count beyond depth")
  `ASSERT_IMPLIES(a_port_clash, clk, rst, ram.we && ram.re, ram.waddr != ram.raddr, "shift read and write share an address")
  `ASSERT_NEXT(a_count_hold, clk, rst, state == S_SHIFT || state == S_READ_WAIT || state == S_DONE, $stable(count), "entry count moved mid transaction")

endmodule
